// ===== rtl/core/ordered_list_engine_core_macros.svh =====
// Assertion helpers used by the checker file.
// Each one expects clk and rst_n in the scope where it is used.
`ifndef ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define OLE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// Next-cycle implication, disabled while in reset
`define OLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

// ===== rtl/core/ole_pkg.sv =====
`timescale 1ns / 1ps

package ole_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int ENTRY_W  = 32;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BOUNDS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Per-cycle action broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE,
        CELL_UPDATE,
        CELL_ROTATE
    } cell_act_t;

    typedef struct packed {
        cell_act_t              act;
        logic [ENTRY_W-1:0]     key;
        logic [ENTRY_W-1:0]     new_value;
        logic [CNT_W-1:0]       count;
        logic [IDX_W-1:0]       pos;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/ole_req_if.sv =====
`timescale 1ns / 1ps

interface ole_req_if import ole_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic signed [POS_W-1:0]     position;
    logic signed [ENTRY_W-1:0]   value;
    logic signed [ENTRY_W-1:0]   new_value;

    modport source (output valid, kind, position, value, new_value, input ready);
    modport sink   (input valid, kind, position, value, new_value, output ready);
endinterface

// ===== rtl/core/ole_rsp_if.sv =====
`timescale 1ns / 1ps

interface ole_rsp_if import ole_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic [CNT_W-1:0]            found_position;
    logic signed [ENTRY_W-1:0]   entry;
    logic [CNT_W-1:0]            length;
    logic                        last;

    modport source (output valid, status, found_position, entry, length, last, input ready);
    modport sink   (input valid, status, found_position, entry, length, last, output ready);
endinterface

// ===== rtl/core/ordered_list_engine_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Carries
// req      in   kind, position, value, new_value
// rsp      out  status, found_position, entry, length, last
//
// Append, insert, delete, update, unused kinds and a dump of an empty list give one transfer.
// A dump of n entries gives n transfers, one per cycle while rsp is not stalled, by rotating
// the cell row once per emitted entry; req is held off until the last of them has been loaded.
// rst_n clears the length and output valid; entries are undefined until written.
// A stalled rsp holds its result and blocks the next request.

module ordered_list_engine_core import ole_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ole_req_if.sink     req,
    ole_rsp_if.source   rsp
);

    cell_ctrl_t          ctrl;
    logic [ENTRY_W-1:0]  head;
    logic                found;
    logic [CNT_W-1:0]    found_pos;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                dump_active_reg, dump_active_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]    fpos_reg, fpos_next;
    logic [ENTRY_W-1:0]  entry_reg, entry_next;
    logic [CNT_W-1:0]    length_reg;
    logic                last_reg, last_next;

    logic                out_free;
    logic                req_fire;
    logic                load;
    logic                pos_bad;
    logic [CNT_W-1:0]    pos_mag;
    logic                full;

    ole_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .head      (head),
        .found     (found),
        .found_pos (found_pos)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !dump_active_reg && out_free;
    assign req_fire  = req.valid && req.ready;

    assign pos_bad = req.position[POS_W-1] || (req.position == '0);
    assign pos_mag = CNT_W'(req.position[POS_W-2:0]);
    assign full    = count_reg >= CNT_W'(CAPACITY);

    // Operation decode and result build
    always_comb
    begin
        ctrl.act         = CELL_HOLD;
        ctrl.key         = req.value;
        ctrl.new_value   = req.new_value;
        ctrl.count       = count_reg;
        ctrl.pos         = IDX_W'(pos_mag);
        load             = 1'b0;
        status_next      = ST_OK;
        fpos_next        = '0;
        entry_next       = '0;
        last_next        = 1'b1;
        count_next       = count_reg;
        dump_active_next = dump_active_reg;
        left_next        = left_reg;

        if (dump_active_reg)
        begin
            if (out_free)
            begin
                ctrl.act         = CELL_ROTATE;
                load             = 1'b1;
                entry_next       = head;
                last_next        = (left_reg == CNT_W'(1));
                left_next        = left_reg - 1'b1;
                dump_active_next = (left_reg != CNT_W'(1));
            end
        end
        else if (req_fire)
        begin
            load = 1'b1;
            case (req.kind)
                KIND_APPEND:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        ctrl.act   = CELL_APPEND;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_INSERT:
                begin
                    if (pos_bad)
                        status_next = ST_INVALID;
                    else if (full)
                        status_next = ST_FULL;
                    else if (pos_mag > count_reg)
                        status_next = ST_BOUNDS;
                    else
                    begin
                        ctrl.act   = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_DELETE:
                begin
                    if (found)
                    begin
                        ctrl.act   = CELL_DELETE;
                        count_next = count_reg - 1'b1;
                    end
                    else
                        status_next = ST_NOTFOUND;
                end
                KIND_UPDATE:
                begin
                    if (found)
                    begin
                        ctrl.act  = CELL_UPDATE;
                        fpos_next = found_pos;
                    end
                    else
                        status_next = ST_NOTFOUND;
                end
                KIND_DUMP:
                begin
                    if (count_reg != '0)
                    begin
                        ctrl.act         = CELL_ROTATE;
                        entry_next       = head;
                        last_next        = (count_reg == CNT_W'(1));
                        left_next        = count_reg - 1'b1;
                        dump_active_next = (count_reg != CNT_W'(1));
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end

        if (load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            dump_active_reg <= 1'b0;
            left_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            dump_active_reg <= dump_active_next;
            left_reg        <= left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            fpos_reg   <= fpos_next;
            entry_reg  <= entry_next;
            length_reg <= count_next;
            last_reg   <= last_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.found_position = fpos_reg;
    assign rsp.entry          = entry_reg;
    assign rsp.length         = length_reg;
    assign rsp.last           = last_reg;

endmodule

// ===== rtl/core/ole_cell.sv =====
`timescale 1ns / 1ps

module ole_cell import ole_pkg::*;
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]    index,
    input  logic [ENTRY_W-1:0]  left_data,
    input  logic [ENTRY_W-1:0]  right_data,
    input  logic [ENTRY_W-1:0]  head_data,
    input  logic                match_in,
    output logic                match_out,
    output logic                first_hit,
    output logic [ENTRY_W-1:0]  data
);

    logic [ENTRY_W-1:0] data_reg;
    logic [ENTRY_W-1:0] data_next;
    logic [CNT_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   idx_inc;
    logic               occupied;
    logic               hit;

    assign idx_ext = CNT_W'(index);
    assign idx_inc = idx_ext + 1'b1;
    assign occupied = idx_ext < ctrl.count;

    // Key compare; match ripples toward the tail so only the first hit wins
    assign hit       = occupied && (data_reg == ctrl.key);
    assign match_out = match_in || hit;
    assign first_hit = hit && !match_in;
    assign data      = data_reg;

    // Next entry value
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.act)
            CELL_APPEND:
            begin
                if (idx_ext == ctrl.count)
                    data_next = ctrl.key;
            end
            CELL_INSERT:
            begin
                if (index == ctrl.pos)
                    data_next = ctrl.key;
                else if (index > ctrl.pos && idx_ext <= ctrl.count)
                    data_next = left_data;
            end
            CELL_DELETE:
            begin
                if (match_out && idx_inc < ctrl.count)
                    data_next = right_data;
            end
            CELL_UPDATE:
            begin
                if (first_hit)
                    data_next = ctrl.new_value;
            end
            CELL_ROTATE:
            begin
                if (idx_inc < ctrl.count)
                    data_next = right_data;
                else if (idx_inc == ctrl.count)
                    data_next = head_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/core/ole_chain.sv =====
`timescale 1ns / 1ps

module ole_chain import ole_pkg::*;
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    output logic [ENTRY_W-1:0]  head,
    output logic                found,
    output logic [CNT_W-1:0]    found_pos
);

    logic [ENTRY_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY:0]  match_chain;
    logic [CAPACITY-1:0] first_vec;

    assign match_chain[0] = 1'b0;

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ole_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .index      (IDX_W'(i)),
            .left_data  (cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
            .head_data  (cell_data[0]),
            .match_in   (match_chain[i]),
            .match_out  (match_chain[i + 1]),
            .first_hit  (first_vec[i]),
            .data       (cell_data[i])
        );
    end

    assign head  = cell_data[0];
    assign found = match_chain[CAPACITY];

    // One-hot first hit to 1-based position
    always_comb
    begin
        found_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_vec[i])
                found_pos = found_pos | CNT_W'(i + 1);
        end
    end

endmodule

// ===== rtl/core/ole_checker.sv =====
`timescale 1ns / 1ps
`include "ordered_list_engine_core_macros.svh"

module ole_checker import ole_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_ready,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic [STATUS_W-1:0] rsp_status,
    input  logic [CNT_W-1:0]    rsp_found_position,
    input  logic [ENTRY_W-1:0]  rsp_entry,
    input  logic [CNT_W-1:0]    rsp_length,
    input  logic                rsp_last
);

    // A stalled result stays offered
    `OLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // Mid-dump, no new request may be taken
    `OLE_ASSERT_IMPL(a_dump_blocks_req, rsp_valid && !rsp_last, !req_ready)

    // A reported position only comes with a successful single result
    `OLE_ASSERT_IMPL(a_fpos_ok, rsp_valid && rsp_found_position != '0, rsp_status == ST_OK && rsp_last)

    // Full status only when the list is at capacity
    `OLE_ASSERT_IMPL(a_full_len, rsp_valid && rsp_status == ST_FULL, rsp_length == CNT_W'(CAPACITY))

    // Entry data only appears on dump results, which are always ok
    `OLE_ASSERT_IMPL(a_entry_ok, rsp_valid && rsp_entry != '0, rsp_status == ST_OK)

endmodule

bind ordered_list_engine_core ole_checker u_ole_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_found_position (rsp.found_position),
    .rsp_entry          (rsp.entry),
    .rsp_length         (rsp.length),
    .rsp_last           (rsp.last)
);

// ===== dv/tb_ordered_list_engine_core.sv =====
`timescale 1ns / 1ps

module tb_ordered_list_engine_core;
    import ole_pkg::*;

    // Kinds with no operation behind them
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    found_pos;
        logic [ENTRY_W-1:0]  entry;
        logic [CNT_W-1:0]    length;
        logic                last;
    } list_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    // Idle controls, written with NBAs so both sides see stable values
    logic no_idle  = 1'b0;
    logic rsp_hold = 1'b0;

    int errors    = 0;
    int cycle_cnt = 0;

    // Shadow copy of the list
    logic [ENTRY_W-1:0] list_mem [CAPACITY];
    int                 list_len = 0;

    // Results still owed by the block, oldest first
    list_rsp_t owed_q[$];

    ole_req_if req_ch();
    ole_rsp_if rsp_ch();

    ordered_list_engine_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_ordered_list_engine_core: errors");
            $finish;
        end
    end

    function automatic int draw_idle();
        if (no_idle)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    // Small values so keys repeat, the extremes, or a random word
    function automatic logic [ENTRY_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // Index of the first entry equal to key, or list_len when absent
    function automatic int find_key(input logic [ENTRY_W-1:0] key);
        for (int i = 0; i < list_len; i++)
        begin
            if (list_mem[i] == key)
                return i;
        end
        return list_len;
    endfunction

    // Apply one operation to the shadow list and queue what it yields
    function automatic void apply_list_op(input logic [KIND_W-1:0] kind,
                                          input logic signed [POS_W-1:0] pos,
                                          input logic [ENTRY_W-1:0] val,
                                          input logic [ENTRY_W-1:0] nval);
        list_rsp_t r;
        int        p;
        int        idx;
        r      = '0;
        r.last = 1'b1;
        p      = pos;
        case (kind)
            KIND_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            KIND_INSERT:
            begin
                // invalid beats full, full beats out of bounds
                if (p <= 0)
                    r.status = ST_INVALID;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else if (p > list_len)
                    r.status = ST_BOUNDS;
                else
                begin
                    for (int i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    list_len++;
                end
            end
            KIND_DELETE:
            begin
                idx = find_key(val);
                if (idx >= list_len)
                    r.status = ST_NOTFOUND;
                else
                begin
                    for (int i = idx; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            KIND_UPDATE:
            begin
                idx = find_key(val);
                if (idx >= list_len)
                    r.status = ST_NOTFOUND;
                else
                begin
                    list_mem[idx] = nval;
                    r.found_pos   = CNT_W'(idx + 1);
                end
            end
            KIND_DUMP:
            begin
                // empty list still answers once; otherwise one transfer per entry
                if (list_len > 0)
                begin
                    for (int i = 0; i < list_len; i++)
                    begin
                        r.entry  = list_mem[i];
                        r.length = CNT_W'(list_len);
                        r.last   = (i + 1 == list_len);
                        owed_q.push_back(r);
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        r.length = CNT_W'(list_len);
        owed_q.push_back(r);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        list_rsp_t want;
        if (owed_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual status %0d entry %0h",
                     $time, rsp_ch.status, rsp_ch.entry);
        end
        else
        begin
            want = owed_q.pop_front();
            check_field("status", want.status, rsp_ch.status);
            check_field("found_position", want.found_pos, rsp_ch.found_position);
            check_field("entry", want.entry, rsp_ch.entry);
            check_field("length", want.length, rsp_ch.length);
            check_field("last", want.last, rsp_ch.last);
        end
    endtask

    // Result side: per-result stall, plus the long hold-off
    initial
    begin : rsp_side
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                check_result();
                stall = draw_idle();
            end
            else if (rsp_ch.valid && stall > 0 && !rsp_hold)
                stall--;
            rsp_ch.ready <= !rsp_hold && (stall == 0);
        end
    end

    // Offer one request and return at the edge of its transfer; valid stays
    // high so a following request with no gap keeps it up
    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic signed [POS_W-1:0] pos,
                           input logic [ENTRY_W-1:0] val,
                           input logic [ENTRY_W-1:0] nval);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.position  <= pos;
        req_ch.value     <= val;
        req_ch.new_value <= nval;
        do
            @(posedge clk);
        while (!req_ch.ready);
        apply_list_op(kind, pos, val, nval);
    endtask

    // Stop offering, wait for every owed result, then let the block settle
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (owed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed operations aimed at live entries, some noise
    task automatic send_random_op();
        logic [KIND_W-1:0]       kind;
        logic signed [POS_W-1:0] pos;
        logic [ENTRY_W-1:0]      val;
        logic [ENTRY_W-1:0]      nval;
        int                      pick;
        pick = $urandom_range(0, 99);
        pos  = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        val  = pick_value();
        nval = $urandom;
        if (pick < 5)
        begin
            kind = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
            val  = $urandom;
        end
        else
        begin
            if (pick < 30)
                kind = KIND_APPEND;
            else if (pick < 52)
                kind = KIND_INSERT;
            else if (pick < 70)
                kind = KIND_DELETE;
            else if (pick < 88)
                kind = KIND_UPDATE;
            else if (pick < 97)
                kind = KIND_DUMP;
            else
                kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            // keep the length moving rather than parked at full
            if ((kind == KIND_APPEND || kind == KIND_INSERT) && list_len > 12
                && $urandom_range(0, 1))
                kind = KIND_DELETE;
            if (kind == KIND_INSERT && $urandom_range(0, 7) != 0)
                pos = (list_len > 0) ? POS_W'($urandom_range(1, list_len)) : POS_W'(1);
            if ((kind == KIND_DELETE || kind == KIND_UPDATE) && list_len > 0
                && $urandom_range(0, 4) != 0)
                val = list_mem[$urandom_range(0, list_len - 1)];
            if (kind == KIND_UPDATE && $urandom_range(0, 1))
                nval = pick_value();
        end
        send_op(kind, pos, val, nval);
    endtask

    // Extremes, every kind, and each error path but full on a short list
    task automatic test_basic_ops();
        send_op(KIND_DUMP, 0, 32'h0, 32'h0);
        send_op(KIND_APPEND, 1, 32'h8000_0000, 32'hffff_ffff);
        send_op(KIND_APPEND, -1, 32'h7fff_ffff, 32'h0);
        send_op(KIND_APPEND, 0, 32'h0000_0000, 32'haaaa_aaaa);
        send_op(KIND_APPEND, 31, 32'hffff_ffff, 32'h5555_5555);
        send_op(KIND_INSERT, 0, 32'h1111_1111, 32'h0);
        send_op(KIND_INSERT, -32, 32'h2222_2222, 32'h0);
        send_op(KIND_INSERT, 31, 32'h3333_3333, 32'h0);
        send_op(KIND_INSERT, 4, 32'h0000_0005, 32'h0);
        // duplicate key ahead of the original
        send_op(KIND_INSERT, 1, 32'h7fff_ffff, 32'h0);
        send_op(KIND_UPDATE, 0, 32'h7fff_ffff, 32'h1234_5678);
        send_op(KIND_UPDATE, 0, 32'h5555_5555, 32'h8000_0000);
        send_op(KIND_DELETE, 0, 32'h7fff_ffff, 32'h0);
        send_op(KIND_DELETE, 0, 32'hdead_beef, 32'h0);
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            send_op(KIND_W'(k), POS_W'($urandom_range(0, (1 << POS_W) - 1)),
                    $urandom, $urandom);
        send_op(KIND_DUMP, 0, 32'h0, 32'h0);
    endtask

    // Fill to capacity, then the full-list precedence cases and a full dump
    task automatic test_full_list();
        while (list_len < CAPACITY)
            send_op(KIND_APPEND, 0, pick_value(), 32'h0);
        send_op(KIND_APPEND, 0, 32'h0bad_0bad, 32'h0);
        send_op(KIND_INSERT, 3, 32'h0bad_0bad, 32'h0);
        send_op(KIND_INSERT, 0, 32'h0bad_0bad, 32'h0);
        send_op(KIND_INSERT, 20, 32'h0bad_0bad, 32'h0);
        send_op(KIND_UPDATE, 0, list_mem[CAPACITY-1], 32'hcafe_f00d);
        send_op(KIND_DUMP, 0, 32'h0, 32'h0);
        send_op(KIND_DELETE, 0, list_mem[CAPACITY-1], 32'h0);
        send_op(KIND_DELETE, 0, list_mem[0], 32'h0);
        send_op(KIND_DUMP, 0, 32'h0, 32'h0);
    endtask

    // Result side holds off for a long stretch while requests keep coming
    task automatic test_rsp_backpressure();
        fork
            begin
                rsp_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 20; i++)
            send_random_op();
    endtask

    // Request side stops until every owed result is back, then resumes
    task automatic test_pause_and_drain();
        for (int i = 0; i < 8; i++)
            send_random_op();
        wait_drained();
        for (int i = 0; i < 8; i++)
            send_random_op();
    endtask

    // Bulk random traffic with a stretch of no idling on either side
    task automatic test_random_ops();
        for (int i = 0; i < 60; i++)
        begin
            if (i % 40 == 20)
                no_idle <= 1'b1;
            else if (i % 40 == 0)
                no_idle <= 1'b0;
            send_random_op();
        end
        no_idle <= 1'b0;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_APPEND;
        req_ch.position  <= '0;
        req_ch.value     <= '0;
        req_ch.new_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_full_list();
        test_rsp_backpressure();
        test_pause_and_drain();
        test_random_ops();
        wait_drained();

        if (errors == 0)
            $display("tb_ordered_list_engine_core: clean");
        else
            $display("tb_ordered_list_engine_core: errors");
        $finish;
    end

endmodule
